// ----- rtl/fcrq_pkg.sv -----
// ----------------------------------------------------------------------------
// fcrq_pkg
// Codes shared by the framed command receiver queue: operations, result
// events, queue status, frame header size and reset start byte.
// ----------------------------------------------------------------------------
package fcrq_pkg;

  typedef logic [1:0] op_t;
  typedef logic [2:0] event_t;
  typedef logic [1:0] qstate_t;

  localparam op_t OP_RX   = 2'd0;
  localparam op_t OP_READ = 2'd1;
  localparam op_t OP_DROP = 2'd2;
  localparam op_t OP_NONE = 2'd3;

  localparam event_t EV_TAKEN        = 3'd0;
  localparam event_t EV_QUEUED       = 3'd1;
  localparam event_t EV_FULL         = 3'd2;
  localparam event_t EV_OVERSIZE     = 3'd3;
  localparam event_t EV_HEAD_BYTE    = 3'd4;
  localparam event_t EV_HEAD_DROPPED = 3'd5;
  localparam event_t EV_EMPTY        = 3'd6;

  localparam qstate_t QS_EMPTY = 2'd0;
  localparam qstate_t QS_DATA  = 2'd1;
  localparam qstate_t QS_FULL  = 2'd2;

  localparam int HEADER_BYTES = 2;
  localparam logic [7:0] START_BYTE_RESET = 8'd170;

endpackage

// ----- rtl/fcrq_ram.sv -----
// ----------------------------------------------------------------------------
// fcrq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fcrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 144
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/framed_command_receiver_queue.sv -----
// ----------------------------------------------------------------------------
// framed_command_receiver_queue
// Hunts a byte stream for the start byte, collects command, length and
// parameter bytes straight into the free tail slot of a frame RAM, and commits
// the slot on frame completion if not full. Reads stream the head frame.
// Receive, drop and empty requests: one result, in the output register the
// cycle after acceptance; one such request per cycle while the output is free.
// Read request: the RAM read is registered, then the head frame streams one
// byte per cycle while the output is free, with last on its final byte.
// Reset clears control state and sets the start byte to 170; RAM is not
// cleared.
// ----------------------------------------------------------------------------
module framed_command_receiver_queue #(
  parameter int QUEUE_DEPTH     = 8,
  parameter int MAX_PARAM_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  fcrq_pkg::op_t       op,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output fcrq_pkg::event_t    event_res,
  output logic [7:0]          out_byte,
  output logic                last,
  output fcrq_pkg::qstate_t   queue_state,
  output logic [2:0]          entries
);

  import fcrq_pkg::*;

  localparam int FRAME_BYTES = MAX_PARAM_BYTES + HEADER_BYTES;
  localparam int MEM_DEPTH   = QUEUE_DEPTH * FRAME_BYTES;
  localparam int AW          = $clog2(MEM_DEPTH);
  localparam int SW          = $clog2(QUEUE_DEPTH);
  localparam int CW          = $clog2(FRAME_BYTES);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_RD_WAIT = 2'd1;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == SW'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [1:0]    state, state_next;
  logic [7:0]    start_byte;
  logic          receiving, receiving_next;
  logic [CW-1:0] rx_count, rx_count_next;
  logic [7:0]    rx_len, rx_len_next;
  logic [SW-1:0] head, head_next;
  logic [SW-1:0] tail, tail_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic [7:0]    rd_len, rd_len_next;

  logic          in_fire, out_free, out_load;
  logic          q_empty, q_full;
  event_t        rx_ev;
  logic [7:0]    len_sel;
  logic [8:0]    cnt_inc;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [CW-1:0] rd_idx_sel;
  logic [7:0]    rd_data;
  logic [7:0]    rd_len_sel;
  logic          rd_last;
  logic          nx_empty, nx_full;
  logic [8:0]    ent_sum;

  event_t        ev_next;
  logic [7:0]    byte_next;
  logic          last_next;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;

  assign q_empty = (head == tail);
  assign q_full  = (head == slot_inc(tail));

  // receive path
  always_comb begin
    rx_ev          = EV_TAKEN;
    receiving_next = receiving;
    rx_count_next  = rx_count;
    rx_len_next    = rx_len;
    tail_next      = tail;
    wr_en          = 1'b0;
    len_sel        = (rx_count == CW'(1)) ? data_byte : rx_len;
    cnt_inc        = 9'(rx_count) + 9'd1;
    if (in_fire && op == OP_RX) begin
      if (!receiving) begin
        if (data_byte == start_byte) begin
          receiving_next = 1'b1;
          rx_count_next  = '0;
        end
      end else begin
        wr_en = 1'b1;
        if (rx_count == CW'(1)) begin
          rx_len_next = data_byte;
        end
        if (rx_count == '0) begin
          rx_count_next = rx_count + 1'b1;
        end else if (rx_count == CW'(1) && {1'b0, data_byte} > 9'(MAX_PARAM_BYTES)) begin
          receiving_next = 1'b0;
          rx_count_next  = '0;
          rx_ev          = EV_OVERSIZE;
        end else if (cnt_inc == {1'b0, len_sel} + 9'(HEADER_BYTES)) begin
          receiving_next = 1'b0;
          rx_count_next  = '0;
          if (q_full) begin
            rx_ev = EV_FULL;
          end else begin
            tail_next = slot_inc(tail);
            rx_ev     = EV_QUEUED;
          end
        end else begin
          rx_count_next = rx_count + 1'b1;
        end
      end
    end
  end

  assign wr_addr = AW'(tail) * AW'(FRAME_BYTES) + AW'(rx_count);

  // head read path
  assign rd_len_sel = ({1'b0, rd_data} > 9'(MAX_PARAM_BYTES)) ? 8'(MAX_PARAM_BYTES) : rd_data;

  always_comb begin
    if (rd_idx == '0) begin
      rd_last = 1'b0;
    end else if (rd_idx == CW'(1)) begin
      rd_last = (rd_len_sel == 8'd0);
    end else begin
      rd_last = (9'(rd_idx) == 9'(rd_len) + 9'd1);
    end
  end

  assign rd_idx_sel = (state == S_IDLE) ? '0 : rd_idx + 1'b1;
  assign rd_addr    = AW'(head) * AW'(FRAME_BYTES) + AW'(rd_idx_sel);

  always_comb begin
    state_next  = state;
    head_next   = head;
    rd_idx_next = rd_idx;
    rd_len_next = rd_len;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    ev_next     = rx_ev;
    byte_next   = 8'd0;
    last_next   = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (op)
            OP_RX: begin
              out_load = 1'b1;
            end
            OP_READ: begin
              if (q_empty) begin
                out_load = 1'b1;
                ev_next  = EV_EMPTY;
              end else begin
                rd_en       = 1'b1;
                rd_idx_next = '0;
                state_next  = S_RD_WAIT;
              end
            end
            OP_DROP: begin
              out_load = 1'b1;
              if (q_empty) begin
                ev_next = EV_EMPTY;
              end else begin
                head_next = slot_inc(head);
                ev_next   = EV_HEAD_DROPPED;
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ev_next   = EV_HEAD_BYTE;
          byte_next = rd_data;
          last_next = rd_last;
          if (rd_idx == CW'(1)) begin
            rd_len_next = rd_len_sel;
          end
          if (rd_last) begin
            state_next = S_IDLE;
          end else begin
            rd_en       = 1'b1;
            rd_idx_next = rd_idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // queue status after the request
  assign nx_empty = (head_next == tail_next);
  assign nx_full  = (head_next == slot_inc(tail_next));
  assign ent_sum  = 9'(tail_next) - 9'(head_next) +
                    ((tail_next < head_next) ? 9'(QUEUE_DEPTH) : 9'd0);

  fcrq_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      start_byte <= START_BYTE_RESET;
      receiving  <= 1'b0;
      rx_count   <= '0;
      head       <= '0;
      tail       <= '0;
      rd_idx     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      receiving <= receiving_next;
      rx_count  <= rx_count_next;
      head      <= head_next;
      tail      <= tail_next;
      rd_idx    <= rd_idx_next;
      if (cfg_valid && cfg_ready) begin
        start_byte <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rx_len <= rx_len_next;
    rd_len <= rd_len_next;
    if (out_load) begin
      event_res   <= ev_next;
      out_byte    <= byte_next;
      last        <= last_next;
      queue_state <= nx_empty ? QS_EMPTY : (nx_full ? QS_FULL : QS_DATA);
      entries     <= ent_sum[2:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_WAIT) |-> (head != tail))
    else $error("head read on empty queue");

  assert property (@(posedge clk) disable iff (rst)
    !receiving |-> (rx_count == '0))
    else $error("byte count held while hunting");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_WAIT && out_free && rd_last) |=> (state == S_IDLE))
    else $error("head read did not end on last byte");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !out_load)
    else $error("result overwritten before taken");

endmodule
